@@ src/hvd_pkg.sv @@
// Shared constants and tables for the haversine distance core.
// Used by hvd_cordic, hvd_sqrt and haversine_distance_core; depends on nothing.
package hvd_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int CW = 34;

   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sh26DD3B6A;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] DEG2RAD_K64 = ((PI_Q60 / 64'd180) + (64'd1 << 23)) >> 24;
   localparam logic signed [31:0] DEG2RAD_K = signed'(DEG2RAD_K64[31:0]);

   localparam int TURN_Q20 = 360 << 20;
   localparam int HALF_TURN_Q20 = 180 << 20;
   localparam int QUARTER_TURN_Q20 = 90 << 20;
   localparam int HALF_ANGLE_SHIFT = 27;
   localparam int FULL_ANGLE_SHIFT = 26;
   localparam int Q30_SHIFT = 30;

   localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

   localparam int SQ_IN_W = 61;
   localparam int SQ_REM_W = 62;
   localparam int SQ_OUT_W = 31;
   localparam int SQ_STEPS = 31;

   localparam logic [46:0] RADIUS_QUARTER = 47'd9897;
   localparam logic [46:0] DIST_ROUND = 47'd20480;
   localparam int DIV_SHIFT = 13;
   localparam int RECIP_SHIFT = 35;
   localparam logic [32:0] RECIP5 = 33'(((64'd1 << 35) + 64'd4) / 64'd5);
   localparam logic [29:0] DIST_MAX = '1;

endpackage

@@ src/hvd_cordic.sv @@
// Pipelined CORDIC, one iteration per register stage, rotation or vectoring mode.
// Depends on hvd_pkg for the word width and the arctangent table.
module hvd_cordic #(
   parameter int STEPS = hvd_pkg::CORDIC_STEPS_DEF,
   parameter bit VECTOR = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic signed [hvd_pkg::CW-1:0] in_x,
   input  logic signed [hvd_pkg::CW-1:0] in_y,
   input  logic signed [hvd_pkg::CW-1:0] in_z,
   output logic                          out_valid,
   output logic signed [hvd_pkg::CW-1:0] out_x,
   output logic signed [hvd_pkg::CW-1:0] out_y,
   output logic signed [hvd_pkg::CW-1:0] out_z
);

   logic signed [hvd_pkg::CW-1:0] x_ff [STEPS];
   logic signed [hvd_pkg::CW-1:0] y_ff [STEPS];
   logic signed [hvd_pkg::CW-1:0] z_ff [STEPS];
   logic [STEPS-1:0] valid_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [hvd_pkg::CW-1:0] xs, ys, zs, x_in, y_in, z_in, atan_k;
      logic minus;
      if (i == 0) begin : g_first
         assign xs = in_x;
         assign ys = in_y;
         assign zs = in_z;
      end else begin : g_next
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
      end
      assign atan_k = hvd_pkg::CW'(signed'({1'b0, hvd_pkg::ATAN_TABLE[i]}));
      if (VECTOR) begin : g_vec
         assign minus = !ys[hvd_pkg::CW-1] && (ys != '0);
      end else begin : g_rot
         assign minus = zs[hvd_pkg::CW-1];
      end
      always_comb begin
         if (minus) begin
            x_in = xs + (ys >>> i);
            y_in = ys - (xs >>> i);
            z_in = zs + atan_k;
         end else begin
            x_in = xs - (ys >>> i);
            y_in = ys + (xs >>> i);
            z_in = zs - atan_k;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[STEPS-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_x = x_ff[STEPS-1];
   assign out_y = y_ff[STEPS-1];
   assign out_z = z_ff[STEPS-1];

endmodule

@@ src/hvd_sqrt.sv @@
// Pipelined exact integer square root, one result bit per register stage.
// Depends on hvd_pkg for its widths and stage count.
module hvd_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic [hvd_pkg::SQ_IN_W-1:0]   in_radicand,
   output logic                          out_valid,
   output logic [hvd_pkg::SQ_OUT_W-1:0]  out_root
);

   localparam int N = hvd_pkg::SQ_STEPS;

   logic [hvd_pkg::SQ_IN_W-1:0]  rem_ff  [N];
   logic [hvd_pkg::SQ_REM_W-1:0] root_ff [N];
   logic [N-1:0] valid_ff;

   for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic [hvd_pkg::SQ_REM_W-1:0] BIT = hvd_pkg::SQ_REM_W'(1) << (2 * (N - 1 - i));
      logic [hvd_pkg::SQ_IN_W-1:0]  rem_s, rem_in;
      logic [hvd_pkg::SQ_REM_W-1:0] root_s, root_in, trial, rem_x;
      logic fits;
      if (i == 0) begin : g_first
         assign rem_s = in_radicand;
         assign root_s = '0;
      end else begin : g_next
         assign rem_s = rem_ff[i-1];
         assign root_s = root_ff[i-1];
      end
      always_comb begin
         trial = root_s + BIT;
         rem_x = {1'b0, rem_s};
         fits = rem_x >= trial;
         rem_in = fits ? hvd_pkg::SQ_IN_W'(rem_x - trial) : rem_s;
         root_in = fits ? (root_s >> 1) + BIT : root_s >> 1;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i] <= rem_in;
            root_ff[i] <= root_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root = root_ff[N-1][hvd_pkg::SQ_OUT_W-1:0];

endmodule

@@ src/haversine_distance_core.sv @@
// Top level of the haversine distance core: request pipeline, output register and skid stage.
// Depends on hvd_pkg, hvd_cordic and hvd_sqrt.
//
// The core takes one request per clock while req_ready is high and returns the great-circle
// distance in miles (16 fraction bits) between two points given in degrees with 20 fraction
// bits. A request passes through stages 0 to 2, the four rotation CORDIC pipelines of
// CORDIC_STEPS stages each, stages 3 to 7, the two parallel 31-stage square root pipelines,
// the vectoring CORDIC, stages 8 to 10 and the output register. When the result side stalls,
// one more result is held in a skid stage before req_ready drops.
module haversine_distance_core #(
   parameter int CORDIC_STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [27:0] req_lat_a,
   input  logic signed [28:0] req_lng_a,
   input  logic signed [27:0] req_lat_b,
   input  logic signed [28:0] req_lng_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [29:0] rsp_distance_miles
);

   localparam int CW = hvd_pkg::CW;
   localparam logic signed [60:0] RND_HALF = 61'sd1 <<< (hvd_pkg::HALF_ANGLE_SHIFT - 1);
   localparam logic signed [60:0] RND_FULL = 61'sd1 <<< (hvd_pkg::FULL_ANGLE_SHIFT - 1);
   localparam logic signed [63:0] RND_Q30 = 64'sd1 <<< (hvd_pkg::Q30_SHIFT - 1);

   logic en;

   // Stage 0: angle differences wrapped to half a turn, latitudes folded for the cosine.
   logic signed [29:0] dlat;
   logic signed [30:0] dlng;
   logic signed [28:0] la, lb, la_abs, lb_abs;
   logic signed [28:0] hlat_in, hlng_in;
   logic signed [27:0] ta_in, tb_in;
   logic nega_in, negb_in;

   always_comb begin
      dlat = 30'(req_lat_b) - 30'(req_lat_a);
      if (dlat >= 30'(hvd_pkg::HALF_TURN_Q20)) begin
         hlat_in = 29'(dlat - 30'(hvd_pkg::TURN_Q20));
      end else if (dlat < -30'(hvd_pkg::HALF_TURN_Q20)) begin
         hlat_in = 29'(dlat + 30'(hvd_pkg::TURN_Q20));
      end else begin
         hlat_in = 29'(dlat);
      end
      dlng = 31'(req_lng_b) - 31'(req_lng_a);
      if (dlng >= 31'(hvd_pkg::HALF_TURN_Q20)) begin
         hlng_in = 29'(dlng - 31'(hvd_pkg::TURN_Q20));
      end else if (dlng < -31'(hvd_pkg::HALF_TURN_Q20)) begin
         hlng_in = 29'(dlng + 31'(hvd_pkg::TURN_Q20));
      end else begin
         hlng_in = 29'(dlng);
      end
      la = 29'(req_lat_a);
      lb = 29'(req_lat_b);
      la_abs = la[28] ? -la : la;
      lb_abs = lb[28] ? -lb : lb;
      nega_in = la_abs > 29'(hvd_pkg::QUARTER_TURN_Q20);
      negb_in = lb_abs > 29'(hvd_pkg::QUARTER_TURN_Q20);
      ta_in = nega_in ? 28'(29'(hvd_pkg::HALF_TURN_Q20) - la_abs) : 28'(la_abs);
      tb_in = negb_in ? 28'(29'(hvd_pkg::HALF_TURN_Q20) - lb_abs) : 28'(lb_abs);
   end

   logic v0_ff;
   logic signed [28:0] hlat_ff, hlng_ff;
   logic signed [27:0] ta_ff, tb_ff;
   logic [1:0] neg0_ff;

   // Stage 1: degrees to radians.
   logic v1_ff;
   logic signed [60:0] pl_ff, pg_ff, pa_ff, pb_ff;
   logic [1:0] neg1_ff;

   // Stage 2: rounded CORDIC angles.
   logic v2_ff;
   logic signed [CW-1:0] zl_ff, zg_ff, za_ff, zb_ff;
   logic [1:0] neg2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hlat_ff <= hlat_in;
         hlng_ff <= hlng_in;
         ta_ff <= ta_in;
         tb_ff <= tb_in;
         neg0_ff <= {negb_in, nega_in};
         pl_ff <= 61'(hlat_ff) * 61'(hvd_pkg::DEG2RAD_K);
         pg_ff <= 61'(hlng_ff) * 61'(hvd_pkg::DEG2RAD_K);
         pa_ff <= 61'(ta_ff) * 61'(hvd_pkg::DEG2RAD_K);
         pb_ff <= 61'(tb_ff) * 61'(hvd_pkg::DEG2RAD_K);
         neg1_ff <= neg0_ff;
         zl_ff <= CW'((pl_ff + RND_HALF) >>> hvd_pkg::HALF_ANGLE_SHIFT);
         zg_ff <= CW'((pg_ff + RND_HALF) >>> hvd_pkg::HALF_ANGLE_SHIFT);
         za_ff <= CW'((pa_ff + RND_FULL) >>> hvd_pkg::FULL_ANGLE_SHIFT);
         zb_ff <= CW'((pb_ff + RND_FULL) >>> hvd_pkg::FULL_ANGLE_SHIFT);
         neg2_ff <= neg1_ff;
      end
   end

   // Sine and cosine pipelines.
   logic rot_valid;
   logic signed [CW-1:0] sl_y, sg_y, ca_x, cb_x;
   logic [1:0] neg_dly_ff [CORDIC_STEPS];

   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_lat (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v2_ff),
      .in_x(hvd_pkg::GAIN_Q30), .in_y('0), .in_z(zl_ff),
      .out_valid(rot_valid), .out_x(), .out_y(sl_y), .out_z()
   );
   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_lng (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v2_ff),
      .in_x(hvd_pkg::GAIN_Q30), .in_y('0), .in_z(zg_ff),
      .out_valid(), .out_x(), .out_y(sg_y), .out_z()
   );
   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_ca (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v2_ff),
      .in_x(hvd_pkg::GAIN_Q30), .in_y('0), .in_z(za_ff),
      .out_valid(), .out_x(ca_x), .out_y(), .out_z()
   );
   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_cb (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v2_ff),
      .in_x(hvd_pkg::GAIN_Q30), .in_y('0), .in_z(zb_ff),
      .out_valid(), .out_x(cb_x), .out_y(), .out_z()
   );

   always_ff @(posedge clock) begin
      if (en) begin
         neg_dly_ff[0] <= neg2_ff;
         for (int i = 1; i < CORDIC_STEPS; i++) begin
            neg_dly_ff[i] <= neg_dly_ff[i-1];
         end
      end
   end

   // Stages 3 to 7: haversine term.
   logic v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [31:0] s1_ff, s2_ff, c1_ff, c2_ff;
   logic signed [63:0] s1sq_p_ff, s2sq_p_ff, cc_p_ff, m2_ff;
   logic signed [31:0] s1sq_ff, s2sq_ff, cc_ff, s1sq_d_ff;
   logic signed [32:0] asum;
   logic [30:0] a_in, a_ff;
   logic [1:0] neg_out;

   assign neg_out = neg_dly_ff[CORDIC_STEPS-1];

   always_comb begin
      asum = 33'(s1sq_d_ff) + 33'((m2_ff + RND_Q30) >>> hvd_pkg::Q30_SHIFT);
      if (asum[32]) begin
         a_in = '0;
      end else if (asum > 33'(hvd_pkg::ONE_Q30)) begin
         a_in = hvd_pkg::ONE_Q30;
      end else begin
         a_in = asum[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= 32'(sl_y);
         s2_ff <= 32'(sg_y);
         c1_ff <= neg_out[0] ? -32'(ca_x) : 32'(ca_x);
         c2_ff <= neg_out[1] ? -32'(cb_x) : 32'(cb_x);
         s1sq_p_ff <= 64'(s1_ff) * 64'(s1_ff);
         s2sq_p_ff <= 64'(s2_ff) * 64'(s2_ff);
         cc_p_ff <= 64'(c1_ff) * 64'(c2_ff);
         s1sq_ff <= 32'((s1sq_p_ff + RND_Q30) >>> hvd_pkg::Q30_SHIFT);
         s2sq_ff <= 32'((s2sq_p_ff + RND_Q30) >>> hvd_pkg::Q30_SHIFT);
         cc_ff <= 32'((cc_p_ff + RND_Q30) >>> hvd_pkg::Q30_SHIFT);
         m2_ff <= 64'(s2sq_ff) * 64'(cc_ff);
         s1sq_d_ff <= s1sq_ff;
         a_ff <= a_in;
      end
   end

   // Square roots and the central angle.
   logic [hvd_pkg::SQ_IN_W-1:0] rad_a, rad_b;
   logic [hvd_pkg::SQ_OUT_W-1:0] root_a, root_b;
   logic sq_valid, vec_valid;
   logic signed [CW-1:0] vec_z;

   assign rad_a = {a_ff, 30'b0};
   assign rad_b = {hvd_pkg::ONE_Q30 - a_ff, 30'b0};

   hvd_sqrt u_sqrt_a (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v7_ff),
      .in_radicand(rad_a), .out_valid(sq_valid), .out_root(root_a)
   );
   hvd_sqrt u_sqrt_b (
      .clock(clock), .reset(reset), .enable(en), .in_valid(v7_ff),
      .in_radicand(rad_b), .out_valid(), .out_root(root_b)
   );

   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vec (
      .clock(clock), .reset(reset), .enable(en), .in_valid(sq_valid),
      .in_x(signed'({3'b0, root_b})), .in_y(signed'({3'b0, root_a})), .in_z('0),
      .out_valid(vec_valid), .out_x(), .out_y(), .out_z(vec_z)
   );

   // Stages 8 to 10: scale to miles, divide by five through a reciprocal, saturate.
   logic v8_ff, v9_ff, v10_ff;
   logic [31:0] ang;
   logic [46:0] nq_ff;
   logic [65:0] mq_ff;
   logic [30:0] quo;
   logic [29:0] dist_in, dist_ff;

   always_comb begin
      ang = vec_z[CW-1] ? '0 : {vec_z[30:0], 1'b0};
      quo = mq_ff[hvd_pkg::RECIP_SHIFT +: 31];
      dist_in = (quo > 31'(hvd_pkg::DIST_MAX)) ? hvd_pkg::DIST_MAX : quo[29:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff <= 47'(ang) * hvd_pkg::RADIUS_QUARTER + hvd_pkg::DIST_ROUND;
         mq_ff <= 66'(nq_ff[hvd_pkg::DIV_SHIFT +: 33]) * 66'(hvd_pkg::RECIP5);
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
         v10_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= rot_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= vec_valid;
         v9_ff <= v8_ff;
         v10_ff <= v9_ff;
      end
   end

   // Output register with one skid entry; the pipeline advances while the skid is empty.
   logic out_v_ff, skid_v_ff;
   logic [29:0] out_dist_ff, skid_dist_ff;

   assign en = !skid_v_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_ready) begin
         if (skid_v_ff) begin
            out_v_ff <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= v10_ff;
         end
      end else if (v10_ff && en) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_ready) begin
         out_dist_ff <= skid_v_ff ? skid_dist_ff : dist_ff;
      end else if (v10_ff && en) begin
         skid_dist_ff <= dist_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_distance_miles = out_dist_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without a pending result");

   a_stall_holds_last: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(v10_ff) && $stable(dist_ff))
      else $error("last pipeline stage moved while the skid entry was full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_ready) |=> !skid_v_ff)
      else $error("skid entry not drained after the result was taken");

   a_term_clamped: assert property (@(posedge clock) disable iff (reset)
      v7_ff |-> (a_ff <= hvd_pkg::ONE_Q30))
      else $error("haversine term above one");

endmodule
